// File: src/sps_pkg.sv
// shared types, codes and coil table for the stepper packet sequencer
`default_nettype none
package sps_pkg;

	// request kinds
	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// parser phases
	localparam logic [2:0] PH_HUNT = 3'd0;
	localparam logic [2:0] PH_HIGH = 3'd1;
	localparam logic [2:0] PH_LOW  = 3'd2;
	localparam logic [2:0] PH_DIR  = 3'd3;
	localparam logic [2:0] PH_ESC  = 3'd4;
	localparam logic [2:0] PH_MODE = 3'd5;

	// packet byte values
	localparam logic [7:0] START_BYTE  = 8'd255;
	localparam logic [7:0] FORCED_BYTE = 8'd255;
	localparam logic [7:0] DIR_FWD     = 8'd1;
	localparam logic [7:0] ESC_HIGH    = 8'd1;
	localparam logic [7:0] ESC_LOW     = 8'd2;
	localparam logic [7:0] ESC_BOTH    = 8'd3;
	localparam logic [7:0] MODE_STEP   = 8'd0;
	localparam logic [7:0] MODE_TIMER  = 8'd1;

	localparam logic [15:0] RESET_PERIOD = 16'd50000;

	// coil pin codes
	localparam logic [1:0] COIL_OFF  = 2'd0;
	localparam logic [1:0] COIL_PIN4 = 2'd1;
	localparam logic [1:0] COIL_PIN5 = 2'd2;

	typedef struct packed {
		logic       req_type;
		logic [7:0] rx_byte;
	} req_t;

	typedef struct packed {
		logic [1:0] coil_a;
		logic [1:0] coil_b;
		logic       drive_written;
	} rsp_t;

	// half-step table: returns {coil_b, coil_a}
	function automatic logic [3:0] coil_lookup(input logic [2:0] idx);
		logic [1:0] a;
		logic [1:0] b;
		begin
			case (idx)
				3'd0: begin a = COIL_PIN4; b = COIL_OFF;  end
				3'd1: begin a = COIL_PIN4; b = COIL_PIN4; end
				3'd2: begin a = COIL_OFF;  b = COIL_PIN4; end
				3'd3: begin a = COIL_PIN5; b = COIL_PIN4; end
				3'd4: begin a = COIL_PIN5; b = COIL_OFF;  end
				3'd5: begin a = COIL_PIN5; b = COIL_PIN5; end
				3'd6: begin a = COIL_OFF;  b = COIL_PIN5; end
				default: begin a = COIL_PIN4; b = COIL_PIN5; end
			endcase
			return {b, a};
		end
	endfunction

endpackage
`default_nettype wire

// File: src/sps_core.sv
// packet parser, tick timer and phase stepper state with the per-request update
`default_nettype none
module sps_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          commit,
	input  wire sps_pkg::req_t item,
	output sps_pkg::rsp_t      result
);

	logic [2:0]  phase_q;
	logic [7:0]  high_q;
	logic [7:0]  low_q;
	logic [7:0]  esc_q;
	logic        fwd_q;
	logic [2:0]  idx_q;
	logic        en_q;
	logic [15:0] period_q;
	logic [15:0] count_q;
	logic [3:0]  coil_q;

	logic [2:0]  phase_d;
	logic [7:0]  high_d;
	logic [7:0]  low_d;
	logic [7:0]  esc_d;
	logic        fwd_d;
	logic [2:0]  idx_d;
	logic        en_d;
	logic [15:0] period_d;
	logic [15:0] count_d;
	logic [3:0]  coil_d;
	logic        wrote;
	logic [2:0]  idx_stepped;
	logic [7:0]  high_eff;
	logic [7:0]  low_eff;

	// one step in the held direction
	assign idx_stepped = fwd_q ? idx_q + 3'd1 : idx_q - 3'd1;

	// escape forcing of the data bytes
	always_comb begin
		high_eff = high_q;
		low_eff  = low_q;
		case (esc_q)
			sps_pkg::ESC_HIGH: high_eff = sps_pkg::FORCED_BYTE;
			sps_pkg::ESC_LOW:  low_eff  = sps_pkg::FORCED_BYTE;
			sps_pkg::ESC_BOTH: begin
				high_eff = sps_pkg::FORCED_BYTE;
				low_eff  = sps_pkg::FORCED_BYTE;
			end
			default: ;
		endcase
	end

	// next state for one request
	always_comb begin
		phase_d  = phase_q;
		high_d   = high_q;
		low_d    = low_q;
		esc_d    = esc_q;
		fwd_d    = fwd_q;
		idx_d    = idx_q;
		en_d     = en_q;
		period_d = period_q;
		count_d  = count_q;
		coil_d   = coil_q;
		wrote    = 1'b0;
		if (item.req_type == sps_pkg::REQ_TICK) begin
			if (period_q != 16'd0) begin
				count_d = (count_q >= period_q) ? 16'd0 : count_q + 16'd1;
				if (count_d == period_q && en_q) begin
					idx_d  = idx_stepped;
					coil_d = sps_pkg::coil_lookup(idx_stepped);
					wrote  = 1'b1;
				end
			end
		end else begin
			case (phase_q)
				sps_pkg::PH_HUNT: begin
					if (item.rx_byte == sps_pkg::START_BYTE) phase_d = sps_pkg::PH_HIGH;
				end
				sps_pkg::PH_HIGH: begin
					high_d  = item.rx_byte;
					phase_d = sps_pkg::PH_LOW;
				end
				sps_pkg::PH_LOW: begin
					low_d   = item.rx_byte;
					phase_d = sps_pkg::PH_DIR;
				end
				sps_pkg::PH_DIR: begin
					fwd_d   = (item.rx_byte == sps_pkg::DIR_FWD);
					phase_d = sps_pkg::PH_ESC;
				end
				sps_pkg::PH_ESC: begin
					esc_d   = item.rx_byte;
					phase_d = sps_pkg::PH_MODE;
				end
				default: begin
					high_d  = high_eff;
					low_d   = low_eff;
					phase_d = sps_pkg::PH_HUNT;
					if (item.rx_byte == sps_pkg::MODE_STEP) begin
						en_d   = 1'b0;
						coil_d = sps_pkg::coil_lookup(idx_q);
						wrote  = 1'b1;
						idx_d  = idx_stepped;
					end else if (item.rx_byte == sps_pkg::MODE_TIMER) begin
						en_d     = 1'b1;
						period_d = {high_eff, low_eff};
					end
				end
			endcase
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= sps_pkg::PH_HUNT;
			high_q   <= 8'd0;
			low_q    <= 8'd0;
			esc_q    <= 8'd0;
			fwd_q    <= 1'b0;
			idx_q    <= 3'd0;
			en_q     <= 1'b1;
			period_q <= sps_pkg::RESET_PERIOD;
			count_q  <= 16'd0;
			coil_q   <= 4'd0;
		end else if (commit) begin
			phase_q  <= phase_d;
			high_q   <= high_d;
			low_q    <= low_d;
			esc_q    <= esc_d;
			fwd_q    <= fwd_d;
			idx_q    <= idx_d;
			en_q     <= en_d;
			period_q <= period_d;
			count_q  <= count_d;
			coil_q   <= coil_d;
		end
	end

	// result shows coil levels held after the request
	always_comb begin
		result.coil_a        = coil_d[1:0];
		result.coil_b        = coil_d[3:2];
		result.drive_written = wrote;
	end

endmodule
`default_nettype wire

// File: src/stepper_packet_sequencer_top.sv
// top level: request register, sequencer core and result register
// Half-step stepper sequencer. Each request is either a received serial byte
// or a timer tick, and every request gives exactly one result with the coil A
// and coil B pin codes held after it and a flag set when the coils were
// written. A request is held in the input register and is then resolved by
// the core into the result register; a new request is taken every cycle
// unless the result register is stalled by rsp_ready low, and the core state
// updates as each request is resolved. The input register keeps taking requests
// while a result waits, until both stages are full.
`default_nettype none
module stepper_packet_sequencer_top (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire sps_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output sps_pkg::rsp_t      rsp
);

	logic          valid_s1;
	sps_pkg::req_t req_s1;
	logic          rsp_valid_q;
	sps_pkg::rsp_t rsp_q;
	sps_pkg::rsp_t result;
	logic          advance;

	// stage 1 moves forward when the result slot is free or being taken
	assign advance   = !rsp_valid_q || rsp_ready;
	assign req_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
	end

	sps_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (valid_s1 && advance),
		.item   (req_s1),
		.result (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

// File: src/sps_checker.sv
// port-level checks for the stepper packet sequencer, bound to the top level
`default_nettype none
module sps_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_ready,
	input wire sps_pkg::req_t req,
	input wire logic          rsp_valid,
	input wire logic          rsp_ready,
	input wire sps_pkg::rsp_t rsp
);

	// a stalled request holds
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("request changed while stalled");

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// no pin code drives both pins of a coil
	a_coil_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.coil_a != 2'd3 && rsp.coil_b != 2'd3)
		else $error("coil code with both pins set");

	// a written drive always energizes at least one coil
	a_drive_on: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.drive_written |-> rsp.coil_a != 2'd0 || rsp.coil_b != 2'd0)
		else $error("written drive with both coils off");

	// with no result waiting a request is always taken
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request stalled with empty result slot");

endmodule

bind stepper_packet_sequencer_top sps_checker u_sps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
`default_nettype wire
